/* hdl/fbrgba_pkg.sv */
// Shared types and constants for the framebuffer to RGB pixel unpacker.
// No dependencies.
`default_nettype none
package fbrgba_pkg;

   localparam int CFG_W     = 11;   // widest configuration register
   localparam int CSR_IDX_W = 2;
   localparam int WORD_W    = 16;
   localparam int CHAN_W    = 8;
   localparam int IDX_W     = 20;   // destination index width
   localparam int SUB_W     = 3;    // pixel number within one source word
   localparam int QDEPTH    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd128;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd64;

   typedef enum logic [1:0] {
      MODE_MONO   = 2'd0,
      MODE_GRAY2  = 2'd1,
      MODE_RGB565 = 2'd2,
      MODE_FILL   = 2'd3
   } color_mode_type;

   localparam logic [SUB_W-1:0] LAST_MONO  = 3'd7;
   localparam logic [SUB_W-1:0] LAST_GRAY2 = 3'd3;
   localparam logic [SUB_W-1:0] LAST_ONE   = 3'd0;

   typedef struct packed {
      color_mode_type    mode;
      logic [WORD_W-1:0] word;
      logic [SUB_W-1:0]  last_sub;
   } entry_type;

endpackage
`default_nettype wire

/* hdl/framebuffer_to_rgba_converter.sv */
// A source word is held in a queue slot, then its pixels in the rsp registers.
// Throughput: one pixel per cycle from the back end pixel counter unless
// stalled; a mono word gives 8 pixels, two-bit gray 4, rgb565 or fill 1.
// Reset (synchronous): registers to mode 0, 128 x 64, raster position zero;
// pixels wait for the row start index to settle after it or a geometry write.
`default_nettype none
module framebuffer_to_rgba_converter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [fbrgba_pkg::WORD_W-1:0]     req_src_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [fbrgba_pkg::IDX_W-1:0]           rsp_pixel_index,
   output logic [fbrgba_pkg::CHAN_W-1:0]          rsp_red,
   output logic [fbrgba_pkg::CHAN_W-1:0]          rsp_green,
   output logic [fbrgba_pkg::CHAN_W-1:0]          rsp_blue,
   output logic                                   rsp_last_of_item,
   output logic                                   rsp_last_of_frame,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fbrgba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fbrgba_pkg::CFG_W-1:0]      csr_wdata
);
   import fbrgba_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic             q_push, q_full, q_pop, q_head_valid;
   entry_type        q_entry, q_head;
   logic [WW-1:0]    eff_width;
   logic [HW-1:0]    eff_height;
   logic [IDX_W-1:0] top_index;
   logic             geom_clear, geom_pending;

   fbrgba_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WW         (WW),
      .HW         (HW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_src_word (req_src_word),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_entry),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .top_index    (top_index),
      .geom_clear   (geom_clear),
      .geom_pending (geom_pending)
   );

   fbrgba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   fbrgba_back #(
      .WW (WW),
      .HW (HW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_head_valid),
      .head_entry        (q_head),
      .pop               (q_pop),
      .eff_width         (eff_width),
      .eff_height        (eff_height),
      .top_index         (top_index),
      .geom_clear        (geom_clear),
      .geom_pending      (geom_pending),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_last_of_item  (rsp_last_of_item),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
`default_nettype wire

/* hdl/fbrgba_front.sv */
// Front end: configuration registers, frame geometry and item intake.
// Classifies each source word and pushes it to the queue. Uses fbrgba_pkg.
`default_nettype none
module fbrgba_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int WW         = 11,
   parameter int HW         = 11
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [fbrgba_pkg::WORD_W-1:0]     req_src_word,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fbrgba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fbrgba_pkg::CFG_W-1:0]      csr_wdata,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output fbrgba_pkg::entry_type                  q_entry,
   output logic [WW-1:0]                          eff_width,
   output logic [HW-1:0]                          eff_height,
   output logic [fbrgba_pkg::IDX_W-1:0]           top_index,
   output logic                                   geom_clear,
   output logic                                   geom_pending
);
   import fbrgba_pkg::*;

   localparam int CAP_W = (MAX_WIDTH / 8) * 8;
   localparam int WH_W  = (WW > HW) ? WW : HW;
   localparam int CMP_W = ((WH_W > CFG_W) ? WH_W : CFG_W) + 1;
   localparam int PW    = ((HW + WW) > IDX_W) ? (HW + WW) : IDX_W;

   color_mode_type    mode_ff, mode_in;
   logic [WW-1:0]     width_ff, width_in;
   logic [HW-1:0]     height_ff, height_in;
   logic [IDX_W-1:0]  top_ff;
   logic              pending_ff;

   logic              csr_xfer;
   logic [CMP_W-1:0]  w_raw, w_clamp, h_raw, h_clamp;
   logic [PW-1:0]     top_prod;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      w_raw = CMP_W'({csr_wdata[CFG_W-1:3], 3'b000});
      if (w_raw < CMP_W'(8)) begin
         w_clamp = CMP_W'(8);
      end else if (w_raw > CMP_W'(CAP_W)) begin
         w_clamp = CMP_W'(CAP_W);
      end else begin
         w_clamp = w_raw;
      end
      h_raw = CMP_W'(csr_wdata);
      if (h_raw < CMP_W'(1)) begin
         h_clamp = CMP_W'(1);
      end else if (h_raw > CMP_W'(MAX_HEIGHT)) begin
         h_clamp = CMP_W'(MAX_HEIGHT);
      end else begin
         h_clamp = h_raw;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      geom_clear = 1'b0;
      if (csr_xfer) begin
         case (csr_index)
            CSR_COLOR_MODE: begin
               mode_in = color_mode_type'(csr_wdata[1:0]);
            end
            CSR_FRAME_WIDTH: begin
               width_in   = w_clamp[WW-1:0];
               geom_clear = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in  = h_clamp[HW-1:0];
               geom_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign top_prod = PW'(height_ff - HW'(1)) * PW'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_MONO;
         width_ff   <= WW'(WIDTH_RESET);
         height_ff  <= HW'(HEIGHT_RESET);
         pending_ff <= 1'b1;
      end else begin
         mode_ff    <= mode_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         pending_ff <= geom_clear;
      end
      top_ff <= top_prod[IDX_W-1:0];
   end

   assign eff_width    = width_ff;
   assign eff_height   = height_ff;
   assign top_index    = top_ff;
   assign geom_pending = pending_ff;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_entry.mode = mode_ff;
      q_entry.word = req_src_word;
      case (mode_ff)
         MODE_MONO:  q_entry.last_sub = LAST_MONO;
         MODE_GRAY2: q_entry.last_sub = LAST_GRAY2;
         default:    q_entry.last_sub = LAST_ONE;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/fbrgba_queue.sv */
// Short show-ahead queue between front end and pixel back end.
// Holds classified source words. Uses fbrgba_pkg.
`default_nettype none
module fbrgba_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire fbrgba_pkg::entry_type push_entry,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       head_valid,
   output fbrgba_pkg::entry_type      head_entry
);
   import fbrgba_pkg::*;

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   entry_type          slot_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ff];

endmodule
`default_nettype wire

/* hdl/fbrgba_back.sv */
// Back end: expands queued words, one pixel per cycle unless stalled, tracks
// raster position and drives the registered result channel. Uses fbrgba_pkg.
`default_nettype none
module fbrgba_back #(
   parameter int WW = 11,
   parameter int HW = 11
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  wire fbrgba_pkg::entry_type             head_entry,
   output logic                                   pop,
   input  wire logic [WW-1:0]                     eff_width,
   input  wire logic [HW-1:0]                     eff_height,
   input  wire logic [fbrgba_pkg::IDX_W-1:0]      top_index,
   input  wire logic                              geom_clear,
   input  wire logic                              geom_pending,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [fbrgba_pkg::IDX_W-1:0]           rsp_pixel_index,
   output logic [fbrgba_pkg::CHAN_W-1:0]          rsp_red,
   output logic [fbrgba_pkg::CHAN_W-1:0]          rsp_green,
   output logic [fbrgba_pkg::CHAN_W-1:0]          rsp_blue,
   output logic                                   rsp_last_of_item,
   output logic                                   rsp_last_of_frame
);
   import fbrgba_pkg::*;

   logic [SUB_W-1:0]  sub_ff, sub_in;
   logic [WW-1:0]     col_ff, col_in, col_next;
   logic [HW-1:0]     row_ff, row_in, row_next;
   logic [IDX_W-1:0]  base_ff, base_in, cur_base;
   logic              valid_ff, valid_in;
   logic [IDX_W-1:0]  index_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff, red_c, green_c, blue_c;
   logic              item_last_ff, frame_last_ff;

   logic              emit, last_sub, row_end, frame_end;
   logic [7:0]        src_byte;
   logic [1:0]        level;
   logic [4:0]        r5, b5;
   logic [5:0]        g6;

   assign emit      = head_valid && !geom_pending && (!valid_ff || rsp_ready);
   assign last_sub  = (sub_ff == head_entry.last_sub);
   assign pop       = emit && last_sub;
   assign col_next  = col_ff + WW'(1);
   assign row_next  = row_ff + HW'(1);
   assign row_end   = (col_next == eff_width);
   assign frame_end = row_end && (row_next == eff_height);
   assign cur_base  = (row_ff == '0) ? top_index : base_ff;

   assign src_byte = head_entry.word[7:0];
   assign r5       = head_entry.word[15:11];
   assign g6       = head_entry.word[10:5];
   assign b5       = head_entry.word[4:0];

   always_comb begin
      case (sub_ff[1:0])
         2'd0:    level = src_byte[7:6];
         2'd1:    level = src_byte[5:4];
         2'd2:    level = src_byte[3:2];
         default: level = src_byte[1:0];
      endcase
      case (head_entry.mode)
         MODE_MONO: begin
            red_c = {CHAN_W{src_byte[sub_ff]}};
         end
         MODE_GRAY2: begin
            red_c = {level, level, level, level};
         end
         MODE_RGB565: begin
            red_c = {r5, r5[4:2]};
         end
         default: begin
            red_c = '0;
         end
      endcase
      green_c = red_c;
      blue_c  = red_c;
      if (head_entry.mode == MODE_RGB565) begin
         green_c = {g6, g6[5:4]};
         blue_c  = {b5, b5[4:2]};
      end
   end

   always_comb begin
      sub_in   = sub_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      base_in  = base_ff;
      valid_in = valid_ff && !rsp_ready;
      if (emit) begin
         valid_in = 1'b1;
         sub_in   = last_sub ? '0 : sub_ff + SUB_W'(1);
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in  = '0;
            row_in  = row_next;
            base_in = cur_base - IDX_W'(eff_width);
         end else begin
            col_in = col_next;
         end
      end
      if (geom_clear) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
      base_ff <= base_in;
      if (emit) begin
         index_ff      <= cur_base + IDX_W'(col_ff);
         red_ff        <= red_c;
         green_ff      <= green_c;
         blue_ff       <= blue_c;
         item_last_ff  <= last_sub;
         frame_last_ff <= frame_end;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_index   = index_ff;
   assign rsp_red           = red_ff;
   assign rsp_green         = green_ff;
   assign rsp_blue          = blue_ff;
   assign rsp_last_of_item  = item_last_ff;
   assign rsp_last_of_frame = frame_last_ff;

endmodule
`default_nettype wire
